// ----- hw/rtl/emgjs_pkg.sv -----
`timescale 1ns / 1ps

package emgjs_pkg;

    localparam int HW_CHANNELS      = 2;
    localparam int NUM_CHANNELS_DEF = 2;

    localparam int CH_W     = 16;
    localparam int COEF_W   = 32;
    localparam int FRAC_W   = 16;
    localparam int OUT_W    = 32;

    localparam int LIN_P_W  = COEF_W + CH_W;
    localparam int LIN_SH   = 15;
    localparam int LIN_W    = LIN_P_W - LIN_SH;
    localparam int SQ_W     = 2 * CH_W;
    localparam int QUAD_P_W = COEF_W + SQ_W;
    localparam int QUAD_SH  = 30;
    localparam int QUAD_W   = QUAD_P_W - QUAD_SH;

    localparam int NUM_W    = 36;
    localparam int DEN_W    = 35;
    localparam int Q_W      = 32;

    localparam int REG_COUNT = 8;
    localparam int REG_IDX_W = 3;

    localparam logic [REG_IDX_W-1:0] IDX_NUM_OFFSET = 3'd0;
    localparam logic [REG_IDX_W-1:0] IDX_NUM_LIN    = 3'd1;
    localparam logic [REG_IDX_W-1:0] IDX_NUM_QUAD   = 3'd3;
    localparam logic [REG_IDX_W-1:0] IDX_DEN_OFFSET = 3'd5;
    localparam logic [REG_IDX_W-1:0] IDX_DEN_LIN    = 3'd6;

    localparam logic [COEF_W-1:0] DEN_OFFSET_RST = 32'h0001_0000;

    localparam logic signed [OUT_W-1:0] Q16_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [OUT_W-1:0] Q16_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic signed [COEF_W-1:0] num_lin;
        logic signed [COEF_W-1:0] num_quad;
        logic signed [COEF_W-1:0] den_lin;
    } lane_coef_t;

    typedef struct packed {
        logic signed [LIN_W-1:0]  num_lin;
        logic signed [QUAD_W-1:0] num_quad;
        logic signed [LIN_W-1:0]  den_lin;
    } lane_terms_t;

    typedef struct packed {
        logic [DEN_W-1:0] rem;
        logic [DEN_W-1:0] dvs;
        logic [Q_W-1:0]   lo;
        logic [Q_W-1:0]   quo;
        logic             neg;
        logic             zero;
        logic             ovf;
        logic [OUT_W-1:0] stiff;
    } div_stage_t;

endpackage

// ----- hw/rtl/emgjs_lane.sv -----
`timescale 1ns / 1ps

module emgjs_lane
    import emgjs_pkg::*;
(
    input  logic              clk,
    input  logic              en,
    input  logic [CH_W-1:0]   x,
    input  lane_coef_t        coef,
    output lane_terms_t       terms
);

    logic signed [LIN_P_W-1:0]  num_lin_prod;
    logic signed [LIN_P_W-1:0]  den_lin_prod;
    logic [SQ_W-1:0]            xsq;
    logic signed [QUAD_P_W-1:0] quad_prod;
    logic signed [LIN_P_W-1:0]  num_lin_rnd;
    logic signed [LIN_P_W-1:0]  den_lin_rnd;
    logic signed [QUAD_P_W-1:0] quad_rnd;

    logic signed [LIN_P_W-1:0]  num_lin_p_reg;
    logic signed [LIN_P_W-1:0]  den_lin_p_reg;
    logic [SQ_W-1:0]            xsq_reg;
    logic signed [QUAD_P_W-1:0] quad_p_reg;
    logic signed [LIN_W-1:0]    num_lin_t_reg;
    logic signed [LIN_W-1:0]    den_lin_t_reg;
    logic signed [LIN_W-1:0]    num_lin_t2_reg;
    logic signed [LIN_W-1:0]    den_lin_t2_reg;
    logic signed [QUAD_W-1:0]   quad_t_reg;

    // products fit their widths exactly: |coef| <= 2^31, x < 2^16, x^2 < 2^32
    assign num_lin_prod = coef.num_lin * $signed({1'b0, x});
    assign den_lin_prod = coef.den_lin * $signed({1'b0, x});
    assign xsq          = x * x;
    assign quad_prod    = coef.num_quad * $signed({1'b0, xsq_reg});

    assign num_lin_rnd = num_lin_p_reg + LIN_P_W'(1 << (LIN_SH - 1));
    assign den_lin_rnd = den_lin_p_reg + LIN_P_W'(1 << (LIN_SH - 1));
    assign quad_rnd    = quad_p_reg + QUAD_P_W'(1 << (QUAD_SH - 1));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_lin_p_reg  <= num_lin_prod;
            den_lin_p_reg  <= den_lin_prod;
            xsq_reg        <= xsq;
            quad_p_reg     <= quad_prod;
            num_lin_t_reg  <= num_lin_rnd[LIN_P_W-1:LIN_SH];
            den_lin_t_reg  <= den_lin_rnd[LIN_P_W-1:LIN_SH];
            quad_t_reg     <= quad_rnd[QUAD_P_W-1:QUAD_SH];
            num_lin_t2_reg <= num_lin_t_reg;
            den_lin_t2_reg <= den_lin_t_reg;
        end
    end

    assign terms.num_lin  = num_lin_t2_reg;
    assign terms.num_quad = quad_t_reg;
    assign terms.den_lin  = den_lin_t2_reg;

endmodule

// ----- hw/rtl/emgjs_merge.sv -----
`timescale 1ns / 1ps

module emgjs_merge
    import emgjs_pkg::*;
#(
    parameter int LANES = NUM_CHANNELS_DEF
)
(
    input  logic                     clk,
    input  logic                     en,
    input  lane_terms_t              terms [LANES],
    input  logic signed [COEF_W-1:0] num_offset,
    input  logic signed [COEF_W-1:0] den_offset,
    output logic signed [NUM_W-1:0]  num,
    output logic signed [DEN_W-1:0]  den
);

    logic signed [NUM_W-1:0] num_sum;
    logic signed [DEN_W-1:0] den_sum;
    logic signed [NUM_W-1:0] num_reg;
    logic signed [DEN_W-1:0] den_reg;

    always_comb
    begin
        num_sum = NUM_W'(num_offset);
        den_sum = DEN_W'(den_offset);
        for (int i = 0; i < LANES; i++)
        begin
            num_sum = num_sum + NUM_W'(terms[i].num_lin) + NUM_W'(terms[i].num_quad);
            den_sum = den_sum + DEN_W'(terms[i].den_lin);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg <= num_sum;
            den_reg <= den_sum;
        end
    end

    assign num = num_reg;
    assign den = den_reg;

endmodule

// ----- hw/rtl/emgjs_div.sv -----
`timescale 1ns / 1ps

module emgjs_div
    import emgjs_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_vld,
    input  logic signed [NUM_W-1:0] num,
    input  logic signed [DEN_W-1:0] den,
    output logic                    out_vld,
    output logic [OUT_W-1:0]        angle,
    output logic [OUT_W-1:0]        stiff,
    output logic                    dz
);

    logic [DEN_W-1:0]        mag_n;
    logic [DEN_W-1:0]        mag_d;
    logic [DEN_W-1:0]        n_hi;
    logic signed [DEN_W:0]   neg_den;
    logic [OUT_W-1:0]        stiff_sat;
    div_stage_t              prep;

    div_stage_t              stg_reg [Q_W+1];
    logic                    vld_reg [Q_W+1];

    logic                    out_vld_reg;
    logic [OUT_W-1:0]        angle_reg;
    logic [OUT_W-1:0]        stiff_reg;
    logic                    dz_reg;
    logic [OUT_W-1:0]        angle_next;
    div_stage_t              fin;

    assign mag_n   = num[NUM_W-1] ? DEN_W'(-num) : DEN_W'(num);
    assign mag_d   = den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
    assign n_hi    = mag_n >> FRAC_W;
    assign neg_den = -(DEN_W+1)'(den);

    always_comb
    begin
        if (neg_den > (DEN_W+1)'(Q16_MAX))
            stiff_sat = Q16_MAX;
        else if (neg_den < (DEN_W+1)'(Q16_MIN))
            stiff_sat = Q16_MIN;
        else
            stiff_sat = neg_den[OUT_W-1:0];
    end

    always_comb
    begin
        prep.rem   = n_hi;
        prep.dvs   = mag_d;
        prep.lo    = {mag_n[FRAC_W-1:0], {(Q_W-FRAC_W){1'b0}}};
        prep.quo   = '0;
        prep.neg   = ~(num[NUM_W-1] ^ den[DEN_W-1]);
        prep.zero  = (den == '0);
        prep.ovf   = (n_hi >= mag_d);
        prep.stiff = stiff_sat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg[0] <= 1'b0;
        else if (en)
            vld_reg[0] <= in_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            stg_reg[0] <= prep;
    end

    for (genvar k = 0; k < Q_W; k++)
    begin : g_step
        logic [DEN_W:0] trial;
        logic [DEN_W:0] diff;
        div_stage_t     nxt;

        always_comb
        begin
            trial = {stg_reg[k].rem, stg_reg[k].lo[Q_W-1]};
            diff  = trial - {1'b0, stg_reg[k].dvs};
            nxt   = stg_reg[k];
            nxt.lo = {stg_reg[k].lo[Q_W-2:0], 1'b0};
            if (!diff[DEN_W])
            begin
                nxt.rem = diff[DEN_W-1:0];
                nxt.quo = {stg_reg[k].quo[Q_W-2:0], 1'b1};
            end
            else
            begin
                nxt.rem = trial[DEN_W-1:0];
                nxt.quo = {stg_reg[k].quo[Q_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k+1] <= 1'b0;
            else if (en)
                vld_reg[k+1] <= vld_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
                stg_reg[k+1] <= nxt;
        end
    end

    assign fin = stg_reg[Q_W];

    always_comb
    begin
        if (fin.ovf)
            angle_next = fin.neg ? Q16_MIN : Q16_MAX;
        else if (fin.neg)
            angle_next = (fin.quo[Q_W-1] && (|fin.quo[Q_W-2:0])) ? Q16_MIN : -fin.quo;
        else
            angle_next = fin.quo[Q_W-1] ? Q16_MAX : fin.quo;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (en)
            out_vld_reg <= vld_reg[Q_W];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            angle_reg <= fin.zero ? '0 : angle_next;
            stiff_reg <= fin.zero ? '0 : fin.stiff;
            dz_reg    <= fin.zero;
        end
    end

    assign out_vld = out_vld_reg;
    assign angle   = angle_reg;
    assign stiff   = stiff_reg;
    assign dz      = dz_reg;

endmodule

// ----- hw/rtl/emg_joint_equilibrium_stiffness.sv -----
`timescale 1ns / 1ps

// Joint equilibrium angle (-num/den) and stiffness (-den) in signed Q15.16 from
// one Q1.15 activity sample per channel, with min(NUM_CHANNELS, 2) channel lanes
// forming the polynomial terms and one merge stage summing them. A new sample is
// taken every cycle unless stalled. Stages: 3 lane multiply/round stages, 1 sum
// stage, 1 sign/overflow stage, 32 one-bit-per-stage restoring divider stages and
// the output register. The whole pipeline stalls while a result waits on m_tready.
// A zero denominator sets tuser and returns angle and stiffness as zero.
// Coefficients are write-only and must be changed only while the pipeline is empty.

module emg_joint_equilibrium_stiffness
    import emgjs_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [REG_IDX_W-1:0] cfg_wr_index,
    input  logic [COEF_W-1:0]    cfg_wr_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [31:0]          s_tdata,   // emg_ch0, emg_ch1
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [63:0]          m_tdata,   // equilibrium_angle, joint_stiffness
    output logic                 m_tuser    // divide_by_zero
);

    localparam int LANES = (NUM_CHANNELS < HW_CHANNELS) ? NUM_CHANNELS : HW_CHANNELS;
    localparam int FRONT = 4;

    logic [COEF_W-1:0]       cfg_reg [REG_COUNT];
    logic                    vld_reg [FRONT];
    logic                    adv;
    lane_terms_t             terms [LANES];
    logic signed [NUM_W-1:0] num;
    logic signed [DEN_W-1:0] den;
    logic [OUT_W-1:0]        angle;
    logic [OUT_W-1:0]        stiff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < REG_COUNT; i++)
                cfg_reg[REG_IDX_W'(i)] <= (i == int'(IDX_DEN_OFFSET)) ? DEN_OFFSET_RST : '0;
        end
        else if (cfg_wr_en)
        begin
            cfg_reg[cfg_wr_index] <= cfg_wr_data;
        end
    end

    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < FRONT; i++)
                vld_reg[i] <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[0] <= s_tvalid;
            for (int i = 1; i < FRONT; i++)
                vld_reg[i] <= vld_reg[i-1];
        end
    end

    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        lane_coef_t coef;

        assign coef.num_lin  = cfg_reg[REG_IDX_W'(int'(IDX_NUM_LIN) + g)];
        assign coef.num_quad = cfg_reg[REG_IDX_W'(int'(IDX_NUM_QUAD) + g)];
        assign coef.den_lin  = cfg_reg[REG_IDX_W'(int'(IDX_DEN_LIN) + g)];

        emgjs_lane u_lane (
            .clk   (clk),
            .en    (adv),
            .x     (s_tdata[g*CH_W +: CH_W]),
            .coef  (coef),
            .terms (terms[g])
        );
    end

    emgjs_merge #(
        .LANES (LANES)
    ) u_merge (
        .clk        (clk),
        .en         (adv),
        .terms      (terms),
        .num_offset (cfg_reg[IDX_NUM_OFFSET]),
        .den_offset (cfg_reg[IDX_DEN_OFFSET]),
        .num        (num),
        .den        (den)
    );

    emgjs_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .in_vld  (vld_reg[FRONT-1]),
        .num     (num),
        .den     (den),
        .out_vld (m_tvalid),
        .angle   (angle),
        .stiff   (stiff),
        .dz      (m_tuser)
    );

    assign m_tdata = {stiff, angle};

endmodule
